[hw/rtl/content_length_message_deframer_core_defines.svh]
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Concurrent checks on clk, held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONTENT_LENGTH_MESSAGE_DEFRAMER_CORE_DEFINES_SVH
`define CONTENT_LENGTH_MESSAGE_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CLMD_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deframer check failed");
`define CLMD_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deframer check failed");
`else
`define CLMD_ASSERT_IMP(name, ante, cons)
`define CLMD_ASSERT_NXT(name, ante, cons)
`endif

`endif

[hw/rtl/clmd_pkg.sv]
// ----------------------------------------------------------------------------
// clmd_pkg
// Shared types, characters and pattern tables of the message deframer.
// ----------------------------------------------------------------------------
package clmd_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_J     = 8'h6A;

	localparam int HDR_LEN = 14;
	localparam logic [8*HDR_LEN-1:0] HDR_NAME = "content-length";

	localparam int PAT_LEN = 41;
	localparam logic [8*PAT_LEN-1:0] PAT_A =
		"{ \"method\" : \"exit\" , \"jsonrpc\" : \"2.0\" }";
	localparam logic [8*PAT_LEN-1:0] PAT_B =
		"{ \"jsonrpc\" : \"2.0\" , \"method\" : \"exit\" }";

	localparam logic [6:0] DFA_START = 7'h00;
	localparam logic [6:0] DFA_DEAD  = 7'h7F;

	typedef enum logic [3:0] {
		PH_NAME  = 4'b0001,
		PH_LEAD  = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	typedef enum logic [3:0] {
		DG_NONE   = 4'b0001,
		DG_DIGITS = 4'b0010,
		DG_DONE   = 4'b0100,
		DG_BAD    = 4'b1000
	} digit_t;

	function automatic logic [7:0] hdr_char(input logic [3:0] pos);
		logic [7:0] c;
		c = 8'h00;
		if (int'(pos) < HDR_LEN) begin
			c = HDR_NAME[8*(HDR_LEN-1-int'(pos)) +: 8];
		end
		return c;
	endfunction

	function automatic logic [7:0] pat_char(input logic alt, input logic [5:0] idx);
		logic [7:0] c;
		c = 8'h00;
		if (int'(idx) < PAT_LEN) begin
			c = alt ? PAT_B[8*(PAT_LEN-1-int'(idx)) +: 8]
			        : PAT_A[8*(PAT_LEN-1-int'(idx)) +: 8];
		end
		return c;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) ||
		       (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
	endfunction

endpackage

[hw/rtl/clmd_exit_dfa.sv]
// ----------------------------------------------------------------------------
// clmd_exit_dfa
// Next-state logic of the streaming matcher for the exit notification body.
// State: bit 6 picks the key order, bits 5:0 the pattern position.
// ----------------------------------------------------------------------------
module clmd_exit_dfa (
	input  logic [6:0] cur_state,
	input  logic [7:0] data,
	output logic [6:0] nxt_state
);

	logic       alt;
	logic [5:0] idx;
	logic [5:0] idx2;
	logic       hold;

	always_comb begin
		alt       = cur_state[6];
		idx       = cur_state[5:0];
		idx2      = idx;
		hold      = 1'b0;
		nxt_state = clmd_pkg::DFA_DEAD;
		if (cur_state != clmd_pkg::DFA_DEAD && int'(idx) < clmd_pkg::PAT_LEN) begin
			// a space in the pattern stands for any run of whitespace
			if (clmd_pkg::pat_char(alt, idx) == clmd_pkg::CH_SP) begin
				if (clmd_pkg::is_ws(data)) begin
					hold = 1'b1;
				end else begin
					idx2 = idx + 6'd1;
				end
			end
			if (hold) begin
				nxt_state = cur_state;
			end else if (!alt && idx2 == 6'd3 && data == clmd_pkg::CH_J) begin
				// first key is jsonrpc: jump over to the other order
				nxt_state = {1'b1, 6'd4};
			end else if (clmd_pkg::pat_char(alt, idx2) == data) begin
				nxt_state = {alt, idx2 + 6'd1};
			end
		end
	end

endmodule

[hw/rtl/content_length_message_deframer_core.sv]
// ----------------------------------------------------------------------------
// content_length_message_deframer_core
// Splits a byte stream of Content-Length framed messages into body beats.
//
//   channel | signals                         | dir | beat
//   in      | in_valid, in_ready, in_byte     | in  | one raw stream byte
//   out     | out_valid, out_ready, body_byte,| out | body byte or message
//           | data_valid, last, is_exit,      |     | end / length error
//           | length_error                    |     |
//
// One byte per cycle while in_ready is high: parse state and result register
// update in the same cycle as the input beat, and out_valid is registered.
// in_ready is high whenever the result register is empty or being drained.
// Headers emit only errors and empty-body ends; reset restarts at the name.
// ----------------------------------------------------------------------------
`include "content_length_message_deframer_core_defines.svh"

module content_length_message_deframer_core #(
	parameter int LENGTH_BITS = clmd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] body_byte,
	output logic       data_valid,
	output logic       last,
	output logic       is_exit,
	output logic       length_error
);

	localparam int MW = LENGTH_BITS + 4;

	clmd_pkg::phase_t        phase_q, n_phase;
	clmd_pkg::digit_t        dig_q, n_dig;
	logic                    cr_q, n_cr;
	logic [3:0]              pos_q, n_pos;
	logic                    mism_q, n_mism;
	logic                    islen_q, n_islen;
	logic                    seen_q, n_seen;
	logic [LENGTH_BITS-1:0]  accum_q, n_accum;
	logic [LENGTH_BITS-1:0]  left_q, n_left;
	logic [6:0]              dfa_q, n_dfa, dfa_step;

	logic                    out_valid_q;
	logic [7:0]              body_q;
	logic                    dv_q, last_q, exit_q, err_q;

	logic                    in_fire;
	logic                    emit;
	logic [7:0]              r_byte;
	logic                    r_dv, r_last, r_exit, r_err;
	logic                    do_start, do_reset;
	logic [MW-1:0]           acc_x10;
	logic [MW-1:0]           acc_sum;
	logic [3:0]              digit;

	clmd_exit_dfa u_dfa (
		.cur_state(dfa_q),
		.data     (in_byte),
		.nxt_state(dfa_step)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// accum*10 + d, overflow when anything lands above LENGTH_BITS
	// ASCII digits carry their value in the low nibble
	assign digit   = in_byte[3:0];
	assign acc_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0};
	assign acc_sum = acc_x10 + {{(MW-4){1'b0}}, digit};

	always_comb begin
		n_phase  = phase_q;
		n_dig    = dig_q;
		n_cr     = cr_q;
		n_pos    = pos_q;
		n_mism   = mism_q;
		n_islen  = islen_q;
		n_seen   = seen_q;
		n_accum  = accum_q;
		n_left   = left_q;
		n_dfa    = dfa_q;
		emit     = 1'b0;
		r_byte   = 8'h00;
		r_dv     = 1'b0;
		r_last   = 1'b0;
		r_exit   = 1'b0;
		r_err    = 1'b0;
		do_start = 1'b0;
		do_reset = 1'b0;

		if (phase_q == clmd_pkg::PH_BODY) begin
			n_dfa  = dfa_step;
			n_left = left_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
			emit   = 1'b1;
			r_byte = in_byte;
			r_dv   = 1'b1;
			if (n_left == '0) begin
				r_last   = 1'b1;
				r_exit   = (int'(dfa_step[5:0]) == clmd_pkg::PAT_LEN) &&
				           (dfa_step != clmd_pkg::DFA_DEAD);
				do_reset = 1'b1;
			end
		end else if (cr_q) begin
			n_cr = 1'b0;
			if (in_byte != clmd_pkg::CH_LF) begin
				do_start = 1'b1;
			end else if (phase_q == clmd_pkg::PH_NAME) begin
				// blank line: body starts if a length header with a nonzero value came before
				if (pos_q == 4'd0 && !mism_q && seen_q) begin
					if (left_q == '0) begin
						emit     = 1'b1;
						r_last   = 1'b1;
						do_reset = 1'b1;
					end else begin
						n_phase = clmd_pkg::PH_BODY;
						n_dfa   = clmd_pkg::DFA_START;
					end
				end else begin
					do_start = 1'b1;
				end
			end else begin
				if (islen_q && (dig_q == clmd_pkg::DG_NONE || dig_q == clmd_pkg::DG_BAD)) begin
					emit     = 1'b1;
					r_err    = 1'b1;
					do_reset = 1'b1;
				end else begin
					if (islen_q) begin
						n_left = accum_q;
					end
					do_start = 1'b1;
				end
			end
		end else if (phase_q == clmd_pkg::PH_NAME) begin
			if (in_byte == clmd_pkg::CH_CR) begin
				n_cr = 1'b1;
			end else if (in_byte == clmd_pkg::CH_LF) begin
				do_start = 1'b1;
			end else if (in_byte == clmd_pkg::CH_COLON) begin
				n_islen = (int'(pos_q) == clmd_pkg::HDR_LEN) && !mism_q;
				if (n_islen) begin
					n_seen = 1'b1;
				end
				n_phase = clmd_pkg::PH_LEAD;
				n_accum = '0;
				n_dig   = clmd_pkg::DG_NONE;
			end else if (!mism_q && int'(pos_q) < clmd_pkg::HDR_LEN &&
			             clmd_pkg::to_lower(in_byte) == clmd_pkg::hdr_char(pos_q)) begin
				n_pos = pos_q + 4'd1;
			end else begin
				n_mism = 1'b1;
			end
		end else if (!(phase_q == clmd_pkg::PH_LEAD &&
		               (in_byte == clmd_pkg::CH_SP || in_byte == clmd_pkg::CH_TAB))) begin
			n_phase = clmd_pkg::PH_VALUE;
			if (in_byte == clmd_pkg::CH_CR) begin
				n_cr = 1'b1;
			end else if (in_byte == clmd_pkg::CH_LF) begin
				do_start = 1'b1;
			end else if (in_byte >= clmd_pkg::CH_ZERO && in_byte <= clmd_pkg::CH_NINE) begin
				if (dig_q == clmd_pkg::DG_NONE || dig_q == clmd_pkg::DG_DIGITS) begin
					if (acc_sum[MW-1:LENGTH_BITS] != '0) begin
						n_dig = clmd_pkg::DG_BAD;
					end else begin
						n_accum = acc_sum[LENGTH_BITS-1:0];
						n_dig   = clmd_pkg::DG_DIGITS;
					end
				end
			end else begin
				if (dig_q == clmd_pkg::DG_NONE) begin
					n_dig = clmd_pkg::DG_BAD;
				end else if (dig_q == clmd_pkg::DG_DIGITS) begin
					n_dig = clmd_pkg::DG_DONE;
				end
			end
		end

		if (do_start || do_reset) begin
			n_phase = clmd_pkg::PH_NAME;
			n_cr    = 1'b0;
			n_pos   = 4'd0;
			n_mism  = 1'b0;
			n_islen = 1'b0;
		end
		if (do_reset) begin
			n_seen  = 1'b0;
			n_accum = '0;
			n_dig   = clmd_pkg::DG_NONE;
			n_left  = '0;
			n_dfa   = clmd_pkg::DFA_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clmd_pkg::PH_NAME;
			dig_q   <= clmd_pkg::DG_NONE;
			cr_q    <= 1'b0;
			pos_q   <= 4'd0;
			mism_q  <= 1'b0;
			islen_q <= 1'b0;
			seen_q  <= 1'b0;
			accum_q <= '0;
			left_q  <= '0;
			dfa_q   <= clmd_pkg::DFA_START;
		end else if (in_fire) begin
			phase_q <= n_phase;
			dig_q   <= n_dig;
			cr_q    <= n_cr;
			pos_q   <= n_pos;
			mism_q  <= n_mism;
			islen_q <= n_islen;
			seen_q  <= n_seen;
			accum_q <= n_accum;
			left_q  <= n_left;
			dfa_q   <= n_dfa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			body_q <= r_byte;
			dv_q   <= r_dv;
			last_q <= r_last;
			exit_q <= r_exit;
			err_q  <= r_err;
		end
	end

	assign out_valid    = out_valid_q;
	assign body_byte    = body_q;
	assign data_valid   = dv_q;
	assign last         = last_q;
	assign is_exit      = exit_q;
	assign length_error = err_q;

	`CLMD_ASSERT_IMP(a_body_has_count, phase_q == clmd_pkg::PH_BODY, left_q != '0)
	`CLMD_ASSERT_IMP(a_exit_on_last, out_valid_q && exit_q, last_q && dv_q)
	`CLMD_ASSERT_IMP(a_err_alone, out_valid_q && err_q, !dv_q && !last_q && !exit_q)
	`CLMD_ASSERT_NXT(a_last_resets, in_fire && emit && r_last, phase_q == clmd_pkg::PH_NAME && !seen_q)

endmodule
